>>> rtl/core/fnc_pkg.sv
// Shared types, constants and arithmetic helpers for the frequency to note block.
// No dependencies; imported by frequency_to_note_cents.
`default_nettype none
package fnc_pkg;

    localparam int FREQ_WIDTH     = 24;
    localparam int FREQ_FRAC_BITS = 8;
    localparam int LOG_FRAC_BITS  = 16;
    localparam int TUNE_WIDTH     = 11;
    localparam int FTOP_WIDTH     = 5;
    localparam int TTOP_WIDTH     = 4;
    localparam int MANT_WIDTH     = LOG_FRAC_BITS + 1;
    localparam int NUM_SQ         = LOG_FRAC_BITS;
    localparam int NUM_STAGES     = NUM_SQ + 5;

    localparam logic [TUNE_WIDTH-1:0] TUNING_RESET = 11'd440;
    // Offset that makes the semitone index nonnegative before dividing by twelve.
    localparam int DIV_OFFSET  = 396;
    localparam int DIV_RECIP   = 2731;
    localparam int DIV_SHIFT   = 15;
    localparam int OCT_BIAS    = DIV_OFFSET / 12;
    localparam int N_MIN       = -384;
    localparam int N_MAX       = 374;

    // Per-stage payload of the log2 squaring chain.
    typedef struct packed {
        logic [MANT_WIDTH-1:0]    mf;
        logic [LOG_FRAC_BITS-1:0] ff;
        logic [FTOP_WIDTH-1:0]    topf;
        logic [MANT_WIDTH-1:0]    mt;
        logic [LOG_FRAC_BITS-1:0] ft;
        logic [TTOP_WIDTH-1:0]    topt;
        logic [TUNE_WIDTH-1:0]    tune;
        logic                     inv;
    } t_sq;

    // 2^(r/12) with 16 fraction bits.
    function automatic logic [16:0] semitone_q16(input logic [3:0] r);
        logic [16:0] v;
        case (r)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd69433;
            4'd2:    v = 17'd73562;
            4'd3:    v = 17'd77936;
            4'd4:    v = 17'd82570;
            4'd5:    v = 17'd87480;
            4'd6:    v = 17'd92682;
            4'd7:    v = 17'd98193;
            4'd8:    v = 17'd104032;
            4'd9:    v = 17'd110218;
            4'd10:   v = 17'd116772;
            4'd11:   v = 17'd123715;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic logic [FTOP_WIDTH-1:0] msb_freq(input logic [FREQ_WIDTH-1:0] v);
        logic [FTOP_WIDTH-1:0] t;
        t = '0;
        for (int i = 0; i < FREQ_WIDTH; i++) begin
            if (v[i]) t = FTOP_WIDTH'(i);
        end
        return t;
    endfunction

    function automatic logic [TTOP_WIDTH-1:0] msb_tune(input logic [TUNE_WIDTH-1:0] v);
        logic [TTOP_WIDTH-1:0] t;
        t = '0;
        for (int i = 0; i < TUNE_WIDTH; i++) begin
            if (v[i]) t = TTOP_WIDTH'(i);
        end
        return t;
    endfunction

    // One fraction bit of log2: square the mantissa and halve it when it reaches two.
    function automatic logic [MANT_WIDTH:0] sq_step(input logic [MANT_WIDTH-1:0] m);
        logic [2*MANT_WIDTH-1:0] p;
        logic [MANT_WIDTH:0]     w;
        p = m * m;
        w = p[2*MANT_WIDTH-1:LOG_FRAC_BITS];
        if (w[MANT_WIDTH]) return {1'b1, w[MANT_WIDTH:1]};
        return {1'b0, w[MANT_WIDTH-1:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/frequency_to_note_cents.sv
// Frequency to equal-tempered note, octave, cents and note frequency.
// Throughput is one per cycle while the output is not stalled.
// The depth is set by the sixteen squaring stages of each fixed-point log2 unit.
// Stages advance independently, so bubbles close up while the output is stalled.
// Reset clears all valid bits and sets the tuning register to 440 Hz.
// Depends on fnc_pkg.
`default_nettype none
module frequency_to_note_cents (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_tuning_we,
    input  wire  [fnc_pkg::TUNE_WIDTH-1:0]        i_tuning_hz,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire  [fnc_pkg::FREQ_WIDTH-1:0]        i_freq,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic signed [5:0]                     o_octave,
    output logic [3:0]                            o_note,
    output logic signed [9:0]                     o_note_index,
    output logic signed [6:0]                     o_cents,
    output logic [fnc_pkg::FREQ_WIDTH-1:0]        o_ref_freq,
    output logic                                  o_invalid
);
    import fnc_pkg::*;

    localparam int SA = NUM_SQ + 1;
    localparam int SB = NUM_SQ + 2;
    localparam int SC = NUM_SQ + 3;
    localparam int SD = NUM_SQ + 4;

    logic [TUNE_WIDTH-1:0] r_tuning;
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tuning <= TUNING_RESET;
        else if (i_tuning_we) r_tuning <= i_tuning_hz;
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        rdy[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage 0: normalize both operands to a mantissa in [1,2).
    t_sq                            r_sq [0:NUM_SQ];
    t_sq                            n_sq0;
    logic [TUNE_WIDTH-1:0]          tune_eff;
    logic [FREQ_WIDTH+LOG_FRAC_BITS-1:0] f_wide;
    logic [TUNE_WIDTH+LOG_FRAC_BITS-1:0] t_wide;

    always_comb begin
        tune_eff       = (r_tuning == '0) ? TUNE_WIDTH'(1) : r_tuning;
        n_sq0.topf     = msb_freq(i_freq);
        n_sq0.topt     = msb_tune(tune_eff);
        f_wide         = {i_freq, {LOG_FRAC_BITS{1'b0}}} >> n_sq0.topf;
        t_wide         = {tune_eff, {LOG_FRAC_BITS{1'b0}}} >> n_sq0.topt;
        n_sq0.mf       = f_wide[MANT_WIDTH-1:0];
        n_sq0.mt       = t_wide[MANT_WIDTH-1:0];
        n_sq0.ff       = '0;
        n_sq0.ft       = '0;
        n_sq0.tune     = tune_eff;
        n_sq0.inv      = (i_freq == '0);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) r_sq[0] <= n_sq0;
    end

    // Stages 1..16: one squaring step per stage for each log2 unit.
    for (genvar j = 1; j <= NUM_SQ; j++) begin : g_sq
        logic [MANT_WIDTH:0] stf;
        logic [MANT_WIDTH:0] stt;
        t_sq                 n_sq;
        always_comb begin
            stf       = sq_step(r_sq[j-1].mf);
            stt       = sq_step(r_sq[j-1].mt);
            n_sq      = r_sq[j-1];
            n_sq.mf   = stf[MANT_WIDTH-1:0];
            n_sq.mt   = stt[MANT_WIDTH-1:0];
            n_sq.ff   = {r_sq[j-1].ff[LOG_FRAC_BITS-2:0], stf[MANT_WIDTH]};
            n_sq.ft   = {r_sq[j-1].ft[LOG_FRAC_BITS-2:0], stt[MANT_WIDTH]};
        end
        always_ff @(posedge i_clk) begin
            if (rdy[j]) r_sq[j] <= n_sq;
        end
    end

    // Stage A: log difference, times twelve, rounded to the nearest semitone.
    localparam int DW = FTOP_WIDTH + LOG_FRAC_BITS + 2;
    localparam int SW = DW + 4;
    logic signed [DW-1:0]  d_a;
    logic signed [SW-1:0]  s_a;
    logic signed [SW-1:0]  t_a;
    logic signed [10:0]    r_n_a, n_n_a;
    logic signed [15:0]    r_rem_a, n_rem_a;
    logic [TUNE_WIDTH-1:0] r_tune_a;
    logic                  r_inv_a;

    always_comb begin
        d_a = $signed(DW'({r_sq[NUM_SQ].topf, r_sq[NUM_SQ].ff}))
            - $signed(DW'({r_sq[NUM_SQ].topt, r_sq[NUM_SQ].ft}))
            - $signed(DW'(FREQ_FRAC_BITS << LOG_FRAC_BITS));
        s_a = (SW'(d_a) <<< 3) + (SW'(d_a) <<< 2);
        t_a = s_a + $signed(SW'(1 << (LOG_FRAC_BITS - 1)));
        n_n_a   = 11'(t_a >>> LOG_FRAC_BITS);
        n_rem_a = {~t_a[LOG_FRAC_BITS-1], t_a[LOG_FRAC_BITS-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SA]) begin
            r_n_a    <= n_n_a;
            r_rem_a  <= n_rem_a;
            r_tune_a <= r_sq[NUM_SQ].tune;
            r_inv_a  <= r_sq[NUM_SQ].inv;
        end
    end

    // Stage B: cents, clamp, and the two divisions by twelve by reciprocal.
    logic [16:0]           mag_b;
    logic [23:0]           prod_b;
    logic [6:0]            cmag_b;
    logic signed [9:0]     nc_b;
    logic [10:0]           xn_b, xi_b;
    logic [22:0]           pn_b, pi_b;
    logic signed [6:0]     r_cents_b, n_cents_b;
    logic signed [9:0]     r_n_b;
    logic [6:0]            r_qn_b, r_qi_b;
    logic [TUNE_WIDTH-1:0] r_tune_b;
    logic                  r_inv_b;

    always_comb begin
        mag_b     = r_rem_a[15] ? 17'(-$signed({r_rem_a[15], r_rem_a})) : 17'(r_rem_a);
        prod_b    = 24'(mag_b) * 24'd100;
        cmag_b    = prod_b[22:16];
        n_cents_b = r_rem_a[15] ? -$signed(cmag_b) : $signed(cmag_b);
        if (r_n_a < 11'(N_MIN)) nc_b = 10'(N_MIN);
        else if (r_n_a > 11'(N_MAX)) nc_b = 10'(N_MAX);
        else nc_b = r_n_a[9:0];
        xn_b = 11'($signed({nc_b[9], nc_b}) + 11'sd396);
        xi_b = 11'($signed({nc_b[9], nc_b}) + 11'sd405);
        pn_b = 23'(xn_b) * 23'(DIV_RECIP);
        pi_b = 23'(xi_b) * 23'(DIV_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SB]) begin
            r_cents_b <= n_cents_b;
            r_n_b     <= nc_b;
            r_qn_b    <= 7'(pn_b >> DIV_SHIFT);
            r_qi_b    <= 7'(pi_b >> DIV_SHIFT);
            r_tune_b  <= r_tune_a;
            r_inv_b   <= r_inv_a;
        end
    end

    // Stage C: octave, note, and tuning times the semitone ratio.
    logic [10:0]           xn_c, xi_c;
    logic [10:0]           rn_c, nt_c;
    logic signed [6:0]     r_sh_c;
    logic [27:0]           r_val_c;
    logic signed [5:0]     r_oct_c;
    logic [3:0]            r_note_c;
    logic signed [9:0]     r_n_c;
    logic signed [6:0]     r_cents_c;
    logic                  r_inv_c;

    always_comb begin
        xn_c = 11'($signed({r_n_b[9], r_n_b}) + 11'sd396);
        xi_c = 11'($signed({r_n_b[9], r_n_b}) + 11'sd405);
        rn_c = xn_c - 11'(r_qn_b) * 11'd12;
        nt_c = xi_c - 11'(r_qi_b) * 11'd12;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SC]) begin
            r_val_c   <= 28'(r_tune_b) * 28'(semitone_q16(rn_c[3:0]));
            r_sh_c    <= $signed(r_qn_b) - 7'(OCT_BIAS) + 7'(FREQ_FRAC_BITS - 16);
            r_oct_c   <= 6'($signed(r_qi_b) - 7'(OCT_BIAS));
            r_note_c  <= nt_c[3:0];
            r_n_c     <= r_n_b;
            r_cents_c <= r_cents_b;
            r_inv_c   <= r_inv_b;
        end
    end

    // Stage D: scale by the octave with rounding and saturation.
    localparam logic [FREQ_WIDTH-1:0] FMAX = '1;
    logic [63:0]          big_d;
    logic [6:0]           rs_d;
    logic [FREQ_WIDTH-1:0] ref_d;

    always_comb begin
        big_d = '0;
        rs_d  = '0;
        if (!r_sh_c[6]) begin
            big_d = 64'(r_val_c) << r_sh_c[5:0];
        end else begin
            rs_d  = 7'(-r_sh_c);
            big_d = (64'(r_val_c) + (64'd1 << (rs_d - 7'd1))) >> rs_d;
        end
        ref_d = (big_d > 64'(FMAX)) ? FMAX : big_d[FREQ_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SD]) begin
            o_octave     <= r_inv_c ? '0 : r_oct_c;
            o_note       <= r_inv_c ? '0 : r_note_c;
            o_note_index <= r_inv_c ? '0 : r_n_c;
            o_cents      <= r_inv_c ? '0 : r_cents_c;
            o_ref_freq   <= r_inv_c ? '0 : ref_d;
            o_invalid    <= r_inv_c;
        end
    end

    assign o_valid = r_v[NUM_STAGES-1];

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_note <= 4'd11)) else $error("note out of range");
    a_cents_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cents >= -7'sd50 && o_cents <= 7'sd50)) else $error("cents out of range");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_ref_freq == '0 && o_note == '0 && o_cents == '0))
        else $error("invalid result carries data");
    a_index_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invalid) |->
        (o_note_index == 10'($signed(o_octave) * 12 + $signed({1'b0, o_note}) - 9)))
        else $error("index does not match octave and note");

endmodule
`default_nettype wire
